### sv/imd_pkg.sv
// Shared constants, mode codes and the pipeline stage record of the multiply/divide unit.
package imd_pkg;

  localparam int DATA_W     = 32;
  localparam int MODE_W     = 3;
  localparam int STEP_N     = 4;
  localparam int DIV_STAGES = DATA_W / STEP_N;
  localparam int IN_TDATA_W = ((MODE_W + 2 * DATA_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_MUL  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DIVU = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMU = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REM  = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              rem_neg;
    logic              quo_neg;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] dvsr;
    logic [DATA_W-1:0] prod;
  } stage_t;

endpackage

### sv/imd_div_stage.sv
// One registered slice of the restoring divider, resolving STEP_N quotient bits.
module imd_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  imd_pkg::stage_t in_data,
  output logic            out_valid,
  output imd_pkg::stage_t out_data
);

  logic            valid_r;
  imd_pkg::stage_t data_r;
  imd_pkg::stage_t data_nxt;

  always_comb begin
    logic [imd_pkg::DATA_W:0] trial;
    data_nxt = in_data;
    for (int i = 0; i < imd_pkg::STEP_N; i++) begin
      // Bring down the next dividend bit, then try the subtraction.
      trial        = {data_nxt.rem, data_nxt.quo[imd_pkg::DATA_W-1]};
      data_nxt.quo = {data_nxt.quo[imd_pkg::DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, data_nxt.dvsr}) begin
        trial           = trial - {1'b0, data_nxt.dvsr};
        data_nxt.quo[0] = 1'b1;
      end
      data_nxt.rem = trial[imd_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### sv/int_mul_div_unit.sv
// Throughput: one transaction per cycle when not stalled; entry stage (multiplier,
// magnitudes), eight divider stages of four restoring steps each, and an output
// register with sign fix-up.
// The whole pipeline advances together and holds while the output is stalled.
// Reset (synchronous, rst_n low) clears every valid bit; data registers are not reset.
module int_mul_div_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: mode[2:0], operand_a[34:3], operand_b[66:35], zero padding.
  input  logic [imd_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: result[31:0].
  output logic [imd_pkg::DATA_W-1:0]       out_tdata
);

  localparam int DW = imd_pkg::DATA_W;
  localparam int MW = imd_pkg::MODE_W;

  logic pipe_en;

  logic [MW-1:0] in_mode;
  logic [DW-1:0] in_a;
  logic [DW-1:0] in_b;

  logic            ent_valid_r;
  imd_pkg::stage_t ent_r;
  imd_pkg::stage_t ent_nxt;

  logic            dv_valid [imd_pkg::DIV_STAGES+1];
  imd_pkg::stage_t dv_data  [imd_pkg::DIV_STAGES+1];

  logic          out_valid_r;
  logic [DW-1:0] out_data_r;
  logic [DW-1:0] out_data_nxt;

  assign pipe_en   = !out_valid_r || out_tready;
  assign in_tready = pipe_en;

  assign in_mode = in_tdata[MW-1:0];
  assign in_a    = in_tdata[MW+DW-1:MW];
  assign in_b    = in_tdata[MW+2*DW-1:MW+DW];

  always_comb begin
    logic signed_op;
    logic a_neg;
    logic b_neg;
    signed_op = (in_mode == imd_pkg::MODE_DIV) || (in_mode == imd_pkg::MODE_REM);
    a_neg     = signed_op && in_a[DW-1];
    b_neg     = signed_op && in_b[DW-1];
    ent_nxt.mode    = in_mode;
    ent_nxt.rem_neg = a_neg;
    ent_nxt.quo_neg = a_neg ^ b_neg;
    ent_nxt.rem     = '0;
    // The most negative value negates to itself, which is the wrap-around wanted.
    ent_nxt.quo     = a_neg ? (~in_a + 1'b1) : in_a;
    ent_nxt.dvsr    = b_neg ? (~in_b + 1'b1) : in_b;
    ent_nxt.prod    = in_a * in_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (pipe_en) begin
      ent_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ent_r <= ent_nxt;
    end
  end

  assign dv_valid[0] = ent_valid_r;
  assign dv_data[0]  = ent_r;

  for (genvar g = 0; g < imd_pkg::DIV_STAGES; g++) begin : g_div
    imd_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (dv_valid[g]),
      .in_data   (dv_data[g]),
      .out_valid (dv_valid[g+1]),
      .out_data  (dv_data[g+1])
    );
  end

  always_comb begin
    imd_pkg::stage_t fin;
    fin = dv_data[imd_pkg::DIV_STAGES];
    case (fin.mode)
      imd_pkg::MODE_MUL:  out_data_nxt = fin.prod;
      imd_pkg::MODE_DIVU: out_data_nxt = fin.quo;
      imd_pkg::MODE_REMU: out_data_nxt = fin.rem;
      imd_pkg::MODE_DIV:  out_data_nxt = fin.quo_neg ? (~fin.quo + 1'b1) : fin.quo;
      imd_pkg::MODE_REM:  out_data_nxt = fin.rem_neg ? (~fin.rem + 1'b1) : fin.rem;
      default:            out_data_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= dv_valid[imd_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A stalled pipeline must keep every transaction in flight where it is.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(ent_valid_r) && $stable(dv_valid[imd_pkg::DIV_STAGES])
                 && $stable(out_data_r))
    else $error("pipeline moved while stalled");

  // A transaction in the last divider stage reaches the output register when it advances.
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && dv_valid[imd_pkg::DIV_STAGES] |=> out_valid_r)
    else $error("transaction lost between divider and output");

  // Reset empties the pipeline.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !ent_valid_r && !out_valid_r)
    else $error("valid bits not cleared by reset");

endmodule

### verif/tb_int_mul_div_unit.sv
// Self-checking testbench for the pipelined integer multiply/divide unit.
module tb_int_mul_div_unit;

  localparam int  MAX_CYCLES = 200000;
  localparam int  DRAIN_CYCLES = 30;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [imd_pkg::IN_TDATA_W-1:0] in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [imd_pkg::DATA_W-1:0]     out_tdata;

  logic [imd_pkg::DATA_W-1:0] expected_results[$];
  int                         mismatches;
  int                         results_seen;
  int                         cycles;
  int                         send_idle_pct;
  int                         recv_idle_pct;
  bit                         recv_hold;
  int                         recv_hold_cycles;

  int_mul_div_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // Restoring division of two unsigned words; divide by zero gives all ones.
  function automatic void udivide(input logic [imd_pkg::DATA_W-1:0] n,
                                  input logic [imd_pkg::DATA_W-1:0] d,
                                  output logic [imd_pkg::DATA_W-1:0] q,
                                  output logic [imd_pkg::DATA_W-1:0] r);
    logic [imd_pkg::DATA_W:0] part;
    if (d == '0) begin
      q = '1;
      r = n;
      return;
    end
    part = '0;
    q = '0;
    for (int i = imd_pkg::DATA_W - 1; i >= 0; i--) begin
      part = {part[imd_pkg::DATA_W-1:0], n[i]};
      if (part >= {1'b0, d}) begin
        part = part - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    r = part[imd_pkg::DATA_W-1:0];
  endfunction

  function automatic logic [imd_pkg::DATA_W-1:0] compute_result(
      input logic [imd_pkg::MODE_W-1:0] mode,
      input logic [imd_pkg::DATA_W-1:0] a,
      input logic [imd_pkg::DATA_W-1:0] b);
    logic [imd_pkg::DATA_W-1:0] q, r, ma, mb;
    logic [2*imd_pkg::DATA_W-1:0] prod;
    ma = a[imd_pkg::DATA_W-1] ? -a : a;
    mb = b[imd_pkg::DATA_W-1] ? -b : b;
    case (mode)
      imd_pkg::MODE_MUL: begin
        prod = a * b;
        return prod[imd_pkg::DATA_W-1:0];
      end
      imd_pkg::MODE_DIVU: begin
        udivide(a, b, q, r);
        return q;
      end
      imd_pkg::MODE_REMU: begin
        udivide(a, b, q, r);
        return r;
      end
      imd_pkg::MODE_DIV: begin
        udivide(ma, mb, q, r);
        return (a[imd_pkg::DATA_W-1] != b[imd_pkg::DATA_W-1]) ? -q : q;
      end
      imd_pkg::MODE_REM: begin
        udivide(ma, mb, q, r);
        return a[imd_pkg::DATA_W-1] ? -r : r;
      end
      default: return '0;
    endcase
  endfunction

  // Offers one transaction, with an optional random gap first, and records its result.
  task automatic send_op(input logic [imd_pkg::MODE_W-1:0] mode,
                         input logic [imd_pkg::DATA_W-1:0] a,
                         input logic [imd_pkg::DATA_W-1:0] b);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(imd_pkg::IN_TDATA_W - imd_pkg::MODE_W - 2 * imd_pkg::DATA_W){1'b0}},
                  b, a, mode};
    expected_results.push_back(compute_result(mode, a, b));
    do @(posedge clk); while (!in_tready);
  endtask

  // The sender stops offering and waits until every outstanding result has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [imd_pkg::DATA_W-1:0] rand_operand();
    case ($urandom_range(5, 0))
      0: return $urandom_range(15, 0);
      1: return -$urandom_range(15, 0);
      2: return $urandom >> $urandom_range(31, 0);
      3: return {1'b1, 31'($urandom_range(3, 0))};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [imd_pkg::DATA_W-1:0] edges[6];
    edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0007};
    // Divide by zero, the most negative value over minus one and the field extremes.
    for (logic [imd_pkg::MODE_W-1:0] m = imd_pkg::MODE_MUL; m <= imd_pkg::MODE_REM; m++) begin
      send_op(m, edges[$urandom_range(5, 0)], 32'h0);
      send_op(m, 32'h8000_0000, 32'hFFFF_FFFF);
      send_op(m, 32'hFFFF_FFF9, 32'h0000_0002);
      send_op(m, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end
    send_op(imd_pkg::MODE_DIV, 32'hFFFF_FFF0, 32'h0);
    send_op(imd_pkg::MODE_REM, 32'hFFFF_FFF0, 32'h0);
    send_op(3'd5, 32'h1234_5678, 32'h9);
    send_op(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(3'd7, 32'h0, 32'h0);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [imd_pkg::MODE_W-1:0] mode;
    for (int i = 0; i < count; i++) begin
      mode = ($urandom_range(19, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
      send_op(mode, rand_operand(), rand_operand());
    end
  endtask

  task automatic test_backpressure();
    recv_hold_cycles = 60;
    recv_hold = 1'b1;
    send_idle_pct = 0;
    test_random(40);
    wait_drained();
    send_idle_pct = 12;
  endtask

  // Receiver: random stalls, or a long counted hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_hold) begin
      out_tready <= 1'b0;
      if (recv_hold_cycles == 0) begin
        recv_hold <= 1'b0;
      end else begin
        recv_hold_cycles <= recv_hold_cycles - 1;
      end
    end else begin
      out_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Compares every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin
    logic [imd_pkg::DATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %h, got %h", want, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    cycles = 0;
    recv_hold = 1'b0;
    recv_hold_cycles = 0;
    send_idle_pct = 12;
    recv_idle_pct = 12;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    test_backpressure();
    // A stretch with no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(100);
    send_idle_pct = 12;
    recv_idle_pct = 12;
    test_random(140);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    $display("Checked %0d results over all five modes, unused modes and divide-by-zero cases,",
             results_seen);
    $display("with random stalls, a long output hold-off and a full-rate stretch.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
